@@ src/ecp_pkg.sv @@
// ----------------------------------------------------------------------------
// ecp_pkg
// Shared types and constants of the encoder commutation position unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecp_pkg;

   localparam int COUNTER_BITS = 16;
   localparam int TABLE_DEPTH  = 4096;

   localparam int CPR_W   = 15;
   localparam int CYC_W   = 5;
   localparam int OFS_W   = 13;
   localparam int CL_W    = 13;
   localparam int COUNT_W = 32;
   localparam int REM_W   = 15;
   localparam int IT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam int SHAFT_W = 14;
   localparam int EPOS_W  = 12;
   localparam int CIDX_W  = 12;

   localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(4000);
   localparam logic [CYC_W-1:0] CYC_RESET = CYC_W'(4);
   localparam logic [CL_W-1:0]  CL_RESET  = CL_W'(4000 / 4);
   localparam logic [CL_W-1:0]  CL_MAX    = CL_W'(TABLE_DEPTH);

   // quarter cycle as a shift, third by reciprocal multiply
   localparam int QUARTER_SHIFT = 2;
   localparam int THIRD_SHIFT   = 17;
   localparam logic [16:0] THIRD_RECIP = 17'd43691;

   // radix-4 iterations for a full and a half width dividend
   localparam logic [IT_W-1:0] ITER_FULL = IT_W'(COUNT_W / 2);
   localparam logic [IT_W-1:0] ITER_HALF = IT_W'(COUNT_W / 4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNTS_PER_REV = 2'd0,
      CSR_CYCLES_PER_REV = 2'd1,
      CSR_ANGLE_OFFSET   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_CL    = 2'd0,
      OP_SHAFT = 2'd1,
      OP_EPOS  = 2'd2,
      OP_IDX   = 2'd3
   } op_type;

   typedef struct packed {
      logic   accept;
      logic   start;
      logic   finish;
      op_type op;
      logic   publish;
   } cmd_type;

   typedef struct packed {
      logic dirty;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ src/ecp_if.sv @@
// ----------------------------------------------------------------------------
// ecp channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] counter_value;
   logic        drive_forward;
   logic [1:0]  phase_number;
   modport source (output valid, counter_value, drive_forward, phase_number, input ready);
   modport sink   (input valid, counter_value, drive_forward, phase_number, output ready);
endinterface

interface ecp_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] shaft_pos;
   logic [11:0] electrical_pos;
   logic [11:0] commutation_index;
   modport source (output valid, shaft_pos, electrical_pos, commutation_index, input ready);
   modport sink   (input valid, shaft_pos, electrical_pos, commutation_index, output ready);
endinterface

interface ecp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [14:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ src/ecp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ecp_ctrl
// Sequencer: count update, cycle length, shaft, electrical and index moduli.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ecp_pkg::status_type status,
   output ecp_pkg::cmd_type        cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_CL_GO  = 10'b0000000010,
      S_CL_RUN = 10'b0000000100,
      S_SH_GO  = 10'b0000001000,
      S_SH_RUN = 10'b0000010000,
      S_EP_GO  = 10'b0000100000,
      S_EP_RUN = 10'b0001000000,
      S_IX_GO  = 10'b0010000000,
      S_IX_RUN = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.accept  = 1'b0;
      cmd.start   = 1'b0;
      cmd.finish  = 1'b0;
      cmd.op      = ecp_pkg::OP_SHAFT;
      cmd.publish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.dirty ? S_CL_GO : S_SH_GO;
            end
         end
         S_CL_GO: begin
            cmd.op    = ecp_pkg::OP_CL;
            cmd.start = 1'b1;
            state_in  = S_CL_RUN;
         end
         S_CL_RUN: begin
            cmd.op = ecp_pkg::OP_CL;
            if (status.div_done) begin
               cmd.finish = 1'b1;
               state_in   = S_SH_GO;
            end
         end
         S_SH_GO: begin
            cmd.op    = ecp_pkg::OP_SHAFT;
            cmd.start = 1'b1;
            state_in  = S_SH_RUN;
         end
         S_SH_RUN: begin
            cmd.op = ecp_pkg::OP_SHAFT;
            if (status.div_done) begin
               cmd.finish = 1'b1;
               state_in   = S_EP_GO;
            end
         end
         S_EP_GO: begin
            cmd.op    = ecp_pkg::OP_EPOS;
            cmd.start = 1'b1;
            state_in  = S_EP_RUN;
         end
         S_EP_RUN: begin
            cmd.op = ecp_pkg::OP_EPOS;
            if (status.div_done) begin
               cmd.finish = 1'b1;
               state_in   = S_IX_GO;
            end
         end
         S_IX_GO: begin
            cmd.op    = ecp_pkg::OP_IDX;
            cmd.start = 1'b1;
            state_in  = S_IX_RUN;
         end
         S_IX_RUN: begin
            cmd.op = ecp_pkg::OP_IDX;
            if (status.div_done) begin
               cmd.finish = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ecp_dpath.sv @@
// ----------------------------------------------------------------------------
// ecp_dpath
// Registers, running count, shared radix-4 remainder unit and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_dpath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ecp_pkg::cmd_type    cmd,
   output ecp_pkg::status_type      status,
   input  wire logic [15:0]         req_counter_value,
   input  wire logic                req_drive_forward,
   input  wire logic [1:0]          req_phase_number,
   input  wire logic                csr_valid,
   input  wire logic [ecp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ecp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [ecp_pkg::SHAFT_W-1:0] rsp_shaft_pos,
   output logic [ecp_pkg::EPOS_W-1:0]  rsp_electrical_pos,
   output logic [ecp_pkg::CIDX_W-1:0]  rsp_commutation_index
);

   localparam int CB = ecp_pkg::COUNTER_BITS;
   localparam int CW = ecp_pkg::COUNT_W;
   localparam int HW = CW / 2;

   // configuration
   logic [ecp_pkg::CPR_W-1:0] cpr_ff, cpr_in;
   logic [ecp_pkg::CYC_W-1:0] cyc_ff, cyc_in;
   logic [ecp_pkg::OFS_W-1:0] ofs_ff, ofs_in;
   logic [ecp_pkg::CL_W-1:0]  cl_ff, cl_in;
   logic                      dirty_ff, dirty_in;

   // item state
   logic [CB-1:0] last_ff, last_in;
   logic [CW-1:0] count_ff, count_in;
   logic          fwd_ff, fwd_in;
   logic [1:0]    phase_ff, phase_in;
   logic [ecp_pkg::CPR_W-1:0] shaft_ff, shaft_in;
   logic [ecp_pkg::EPOS_W-1:0] epos_ff, epos_in;
   logic [ecp_pkg::CIDX_W-1:0] idx_ff, idx_in;
   logic [ecp_pkg::CL_W-1:0]  third_ff, third_in;

   // remainder unit
   logic [CW-1:0]                  dsr_ff, dsr_in;
   logic [ecp_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [ecp_pkg::CPR_W-1:0]      dvs_ff, dvs_in;
   logic [ecp_pkg::IT_W-1:0]       it_ff, it_in;
   logic                           neg_ff, neg_in;

   // result stage
   logic                           ovalid_ff, ovalid_in;
   logic [ecp_pkg::SHAFT_W-1:0]    oshaft_ff, oshaft_in;
   logic [ecp_pkg::EPOS_W-1:0]     oepos_ff, oepos_in;
   logic [ecp_pkg::CIDX_W-1:0]     oidx_ff, oidx_in;

   // combinational helpers
   logic [CB-1:0]  diff;
   logic [CW-1:0]  count_mag;
   logic [HW:0]    r1, r2, r1s, r2s;
   logic           q1, q2;
   logic [HW-1:0]  quot;
   logic [ecp_pkg::CYC_W-1:0] cyc_div;
   logic [ecp_pkg::CL_W:0]    clp;
   logic [30:0]    third_prod;
   logic [HW-1:0]  quarter, isum, imag;
   logic [ecp_pkg::CPR_W-1:0] rsub;
   logic           rnz;

   always_comb begin
      diff      = req_counter_value[CB-1:0] - last_ff;
      count_mag = count_ff[CW-1] ? (~count_ff + CW'(1)) : count_ff;
      cyc_div   = (cyc_ff == '0) ? ecp_pkg::CYC_W'(1) : cyc_ff;

      // two restoring steps per cycle
      r1  = {1'b0, rem_ff, dsr_ff[CW-1]};
      q1  = (r1 >= {2'b0, dvs_ff});
      r1s = q1 ? (r1 - {2'b0, dvs_ff}) : r1;
      r2  = {1'b0, r1s[ecp_pkg::REM_W-1:0], dsr_ff[CW-2]};
      q2  = (r2 >= {2'b0, dvs_ff});
      r2s = q2 ? (r2 - {2'b0, dvs_ff}) : r2;
      quot = dsr_ff[HW-1:0];

      case (phase_ff)
         2'd0:    clp = '0;
         2'd1:    clp = {1'b0, cl_ff};
         2'd2:    clp = {cl_ff, 1'b0};
         default: clp = {cl_ff, 1'b0} + {1'b0, cl_ff};
      endcase
      third_prod = 31'(clp) * 31'(ecp_pkg::THIRD_RECIP);

      quarter = HW'(cl_ff >> ecp_pkg::QUARTER_SHIFT);
      isum    = HW'(epos_ff) + (fwd_ff ? (~quarter + HW'(1)) : quarter)
                + HW'(third_ff) + {{(HW-ecp_pkg::OFS_W){ofs_ff[ecp_pkg::OFS_W-1]}}, ofs_ff};
      imag    = isum[HW-1] ? (~isum + HW'(1)) : isum;

      rnz  = (rem_ff != '0);
      rsub = dvs_ff - rem_ff;
   end

   always_comb begin
      cpr_in    = cpr_ff;
      cyc_in    = cyc_ff;
      ofs_in    = ofs_ff;
      cl_in     = cl_ff;
      dirty_in  = dirty_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      fwd_in    = fwd_ff;
      phase_in  = phase_ff;
      shaft_in  = shaft_ff;
      epos_in   = epos_ff;
      idx_in    = idx_ff;
      third_in  = third_ff;
      dsr_in    = dsr_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      it_in     = it_ff;
      neg_in    = neg_ff;
      ovalid_in = ovalid_ff;
      oshaft_in = oshaft_ff;
      oepos_in  = oepos_ff;
      oidx_in   = oidx_ff;

      if (csr_valid) begin
         case (csr_index)
            ecp_pkg::CSR_COUNTS_PER_REV: begin
               cpr_in   = csr_wdata[ecp_pkg::CPR_W-1:0];
               dirty_in = 1'b1;
            end
            ecp_pkg::CSR_CYCLES_PER_REV: begin
               cyc_in   = csr_wdata[ecp_pkg::CYC_W-1:0];
               dirty_in = 1'b1;
            end
            ecp_pkg::CSR_ANGLE_OFFSET: begin
               ofs_in = csr_wdata[ecp_pkg::OFS_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         last_in  = req_counter_value[CB-1:0];
         count_in = count_ff + {{(CW-CB){diff[CB-1]}}, diff};
         fwd_in   = req_drive_forward;
         phase_in = req_phase_number;
      end

      if (it_ff != '0) begin
         dsr_in = {dsr_ff[CW-3:0], q1, q2};
         rem_in = r2s[ecp_pkg::REM_W-1:0];
         it_in  = it_ff - ecp_pkg::IT_W'(1);
      end

      if (cmd.start) begin
         rem_in = '0;
         neg_in = 1'b0;
         case (cmd.op)
            ecp_pkg::OP_CL: begin
               dsr_in = {1'b0, cpr_ff, HW'(0)};
               dvs_in = ecp_pkg::CPR_W'(cyc_div);
               it_in  = ecp_pkg::ITER_HALF;
            end
            ecp_pkg::OP_SHAFT: begin
               dsr_in = count_mag;
               dvs_in = cpr_ff;
               neg_in = count_ff[CW-1];
               it_in  = ecp_pkg::ITER_FULL;
            end
            ecp_pkg::OP_EPOS: begin
               dsr_in   = {1'b0, shaft_ff, HW'(0)};
               dvs_in   = ecp_pkg::CPR_W'(cl_ff);
               third_in = third_prod[ecp_pkg::THIRD_SHIFT +: ecp_pkg::CL_W];
               it_in    = ecp_pkg::ITER_HALF;
            end
            default: begin
               dsr_in = {imag, HW'(0)};
               dvs_in = ecp_pkg::CPR_W'(cl_ff);
               neg_in = isum[HW-1];
               it_in  = ecp_pkg::ITER_HALF;
            end
         endcase
      end

      if (cmd.finish) begin
         case (cmd.op)
            ecp_pkg::OP_CL: begin
               cl_in    = (quot > HW'(ecp_pkg::CL_MAX)) ? ecp_pkg::CL_MAX
                                                        : quot[ecp_pkg::CL_W-1:0];
               dirty_in = 1'b0;
            end
            ecp_pkg::OP_SHAFT: begin
               if (dvs_ff == '0) begin
                  shaft_in = '0;
               end else begin
                  shaft_in = (neg_ff && rnz) ? rsub : rem_ff;
               end
            end
            ecp_pkg::OP_EPOS: begin
               epos_in = (dvs_ff == '0) ? '0 : rem_ff[ecp_pkg::EPOS_W-1:0];
            end
            default: begin
               if (dvs_ff == '0) begin
                  idx_in = '0;
               end else begin
                  idx_in = (neg_ff && rnz) ? rsub[ecp_pkg::CIDX_W-1:0]
                                           : rem_ff[ecp_pkg::CIDX_W-1:0];
               end
            end
         endcase
      end

      if (ovalid_ff && rsp_ready) begin
         ovalid_in = 1'b0;
      end
      if (cmd.publish) begin
         ovalid_in = 1'b1;
         oshaft_in = shaft_ff[ecp_pkg::SHAFT_W-1:0];
         oepos_in  = epos_ff;
         oidx_in   = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff    <= ecp_pkg::CPR_RESET;
         cyc_ff    <= ecp_pkg::CYC_RESET;
         ofs_ff    <= '0;
         cl_ff     <= ecp_pkg::CL_RESET;
         dirty_ff  <= 1'b0;
         last_ff   <= '0;
         count_ff  <= '0;
         it_ff     <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         cpr_ff    <= cpr_in;
         cyc_ff    <= cyc_in;
         ofs_ff    <= ofs_in;
         cl_ff     <= cl_in;
         dirty_ff  <= dirty_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         it_ff     <= it_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff    <= fwd_in;
      phase_ff  <= phase_in;
      shaft_ff  <= shaft_in;
      epos_ff   <= epos_in;
      idx_ff    <= idx_in;
      third_ff  <= third_in;
      dsr_ff    <= dsr_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      oshaft_ff <= oshaft_in;
      oepos_ff  <= oepos_in;
      oidx_ff   <= oidx_in;
   end

   assign status.dirty    = dirty_ff;
   assign status.div_done = (it_ff == '0);
   assign status.out_free = !ovalid_ff || rsp_ready;

   assign rsp_valid             = ovalid_ff;
   assign rsp_shaft_pos         = oshaft_ff;
   assign rsp_electrical_pos    = oepos_ff;
   assign rsp_commutation_index = oidx_ff;

endmodule

`default_nettype wire

@@ src/encoder_commutation_position_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_commutation_position_unit
// Tracks an encoder counter and gives shaft, electrical and commutation index.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                            handshake
//  req_ch   in   counter_value, drive_forward, phase_number         valid/ready
//  rsp_ch   out  shaft_pos, electrical_pos, commutation_index       valid/ready
//  csr_ch   in   index, wdata                                       valid/ready
//
//  one transaction in the datapath and one in the output register; a write to
//  counts_per_rev or cycles_per_rev forces a new cycle length first; input is
//  ready again only once the result has moved to the output register, so a new
//  sample is not taken while one is still in progress
//  the shared radix-4 remainder unit takes 16 steps for the shaft modulo,
//  8 each for cycle length, electrical position and index, plus handoffs
//  synchronous reset restores the register defaults and clears the count
//  a stalled result holds in the output register; csr writes never stall
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_commutation_position_unit (
   input  wire logic clock,
   input  wire logic reset,
   ecp_req_if.sink   req_ch,
   ecp_rsp_if.source rsp_ch,
   ecp_csr_if.sink   csr_ch
);

   ecp_pkg::cmd_type    cmd;
   ecp_pkg::status_type status;
   logic                req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   ecp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecp_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_counter_value     (req_ch.counter_value),
      .req_drive_forward     (req_ch.drive_forward),
      .req_phase_number      (req_ch.phase_number),
      .csr_valid             (csr_ch.valid),
      .csr_index             (csr_ch.index),
      .csr_wdata             (csr_ch.wdata),
      .rsp_valid             (rsp_ch.valid),
      .rsp_ready             (rsp_ch.ready),
      .rsp_shaft_pos         (rsp_ch.shaft_pos),
      .rsp_electrical_pos    (rsp_ch.electrical_pos),
      .rsp_commutation_index (rsp_ch.commutation_index)
   );

endmodule

`default_nettype wire

@@ src/ecp_checker.sv @@
// ----------------------------------------------------------------------------
// ecp_checker
// Port level checks of the encoder commutation position unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [13:0] rsp_shaft_pos,
   input wire logic [11:0] rsp_electrical_pos,
   input wire logic [11:0] rsp_commutation_index,
   input wire logic        csr_ready
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one transaction at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while busy");

   // a stalled result does not change when a transaction is taken
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid || rsp_ready || $stable(rsp_shaft_pos))
      else $error("result changed while stalled");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_shaft_pos)
         && $stable(rsp_electrical_pos) && $stable(rsp_commutation_index))
      else $error("stalled result not held");

   // register writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register write stalled");

endmodule

bind encoder_commutation_position_unit ecp_checker u_ecp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_ch.valid),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_shaft_pos         (rsp_ch.shaft_pos),
   .rsp_electrical_pos    (rsp_ch.electrical_pos),
   .rsp_commutation_index (rsp_ch.commutation_index),
   .csr_ready             (csr_ch.ready)
);

`default_nettype wire

@@ verif/encoder_commutation_position_unit_test.sv @@
// ----------------------------------------------------------------------------
// encoder_commutation_position_unit_test
// Drives encoder samples through several register settings with random
// bursts, gaps and receiver stalls, and checks every result against a
// cycle-free model of the position and commutation index arithmetic.
// ----------------------------------------------------------------------------
module encoder_commutation_position_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUARTER_DIV     = 4;
   localparam int THIRD_DIV       = 3;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 60;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int FIXED_PHASES    = 9;
   localparam int RANDOM_PHASES   = 3;

   typedef struct packed {
      logic [ecp_pkg::SHAFT_W-1:0] shaft_pos;
      logic [ecp_pkg::EPOS_W-1:0]  electrical_pos;
      logic [ecp_pkg::CIDX_W-1:0]  commutation_index;
   } position_result_type;

   class position_tracker_type;
      logic [ecp_pkg::CPR_W-1:0]        counts_per_rev;
      logic [ecp_pkg::CYC_W-1:0]        cycles_per_rev;
      logic signed [ecp_pkg::OFS_W-1:0] angle_offset;
      logic [ecp_pkg::COUNTER_BITS-1:0] last_sample;
      logic [ecp_pkg::COUNT_W-1:0]      running_count;
      longint                           cycle_length;
      position_result_type              expected_positions[$];
      int                               mismatch_count;

      function new();
         counts_per_rev = ecp_pkg::CPR_RESET;
         cycles_per_rev = ecp_pkg::CYC_RESET;
         angle_offset   = '0;
         last_sample    = '0;
         running_count  = '0;
         mismatch_count = 0;
         update_cycle_length();
      endfunction

      function void update_cycle_length();
         longint cyc;
         cyc = (cycles_per_rev == 0) ? 1 : longint'(cycles_per_rev);
         cycle_length = longint'(counts_per_rev) / cyc;
         if (cycle_length > ecp_pkg::TABLE_DEPTH) begin
            cycle_length = ecp_pkg::TABLE_DEPTH;
         end
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      function int pending();
         return expected_positions.size();
      endfunction

      function void write_register(ecp_pkg::csr_index_type idx,
                                   logic [ecp_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            ecp_pkg::CSR_COUNTS_PER_REV: begin
               counts_per_rev = data[ecp_pkg::CPR_W-1:0];
               update_cycle_length();
            end
            ecp_pkg::CSR_CYCLES_PER_REV: begin
               cycles_per_rev = data[ecp_pkg::CYC_W-1:0];
               update_cycle_length();
            end
            ecp_pkg::CSR_ANGLE_OFFSET: begin
               angle_offset = data[ecp_pkg::OFS_W-1:0];
            end
            default: ;
         endcase
      endfunction

      function void note_sample(logic [ecp_pkg::COUNTER_BITS-1:0] counter, logic forward,
                                logic [1:0] phase);
         logic [ecp_pkg::COUNTER_BITS-1:0] diff;
         longint delta, cnt, cpr, cl, ph, ofs, shaft, epos, idx;
         position_result_type r;
         diff = counter - last_sample;
         delta = $signed(diff);
         last_sample = counter;
         running_count = running_count + delta[ecp_pkg::COUNT_W-1:0];
         cnt = $signed(running_count);
         shaft = 0;
         if (counts_per_rev != 0) begin
            cpr = longint'(counts_per_rev);
            shaft = cnt % cpr;
            if (shaft < 0) begin
               shaft += cpr;
            end
         end
         epos = 0;
         idx = 0;
         if (cycle_length != 0) begin
            cl = cycle_length;
            ph = longint'(phase);
            ofs = angle_offset;
            epos = shaft % cl;
            idx = epos + (forward ? -(cl / QUARTER_DIV) : (cl / QUARTER_DIV))
                  + (cl * ph) / THIRD_DIV + ofs;
            idx = idx % cl;
            if (idx < 0) begin
               idx += cl;
            end
         end
         r.shaft_pos         = shaft[ecp_pkg::SHAFT_W-1:0];
         r.electrical_pos    = epos[ecp_pkg::EPOS_W-1:0];
         r.commutation_index = idx[ecp_pkg::CIDX_W-1:0];
         expected_positions.push_back(r);
      endfunction

      task check_position(position_result_type got);
         position_result_type want;
         if (expected_positions.size() == 0) begin
            report($sformatf("result with no pending sample: %p", got));
         end else begin
            want = expected_positions.pop_front();
            if (got.shaft_pos !== want.shaft_pos) begin
               report($sformatf("shaft_pos got %0d want %0d",
                                got.shaft_pos, want.shaft_pos));
            end
            if (got.electrical_pos !== want.electrical_pos) begin
               report($sformatf("electrical_pos got %0d want %0d",
                                got.electrical_pos, want.electrical_pos));
            end
            if (got.commutation_index !== want.commutation_index) begin
               report($sformatf("commutation_index got %0d want %0d",
                                got.commutation_index, want.commutation_index));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic hold_off_request;
   logic [ecp_pkg::COUNTER_BITS-1:0] counter_now;
   position_tracker_type tracker = new();

   ecp_req_if req_ch();
   ecp_rsp_if rsp_ch();
   ecp_csr_if csr_ch();

   encoder_commutation_position_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task send_sample(logic [ecp_pkg::COUNTER_BITS-1:0] cv, logic forward, logic [1:0] phase);
      req_ch.valid         <= 1'b1;
      req_ch.counter_value <= cv;
      req_ch.drive_forward <= forward;
      req_ch.phase_number  <= phase;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      tracker.note_sample(cv, forward, phase);
      counter_now = cv;
   endtask

   task put_register(ecp_pkg::csr_index_type idx, logic [ecp_pkg::CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   task apply_setting(int cpr, int cyc, int ofs);
      logic [ecp_pkg::CSR_DATA_W-1:0] pad;
      put_register(ecp_pkg::CSR_COUNTS_PER_REV, ecp_pkg::CSR_DATA_W'(cpr));
      pad = ecp_pkg::CSR_DATA_W'($urandom);
      pad[ecp_pkg::CYC_W-1:0] = ecp_pkg::CYC_W'(cyc);
      put_register(ecp_pkg::CSR_CYCLES_PER_REV, pad);
      pad = ecp_pkg::CSR_DATA_W'($urandom);
      pad[ecp_pkg::OFS_W-1:0] = ecp_pkg::OFS_W'(ofs);
      put_register(ecp_pkg::CSR_ANGLE_OFFSET, pad);
      csr_ch.valid <= 1'b0;
   endtask

   // lower valid and wait until every accepted sample has its result
   task drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int seg_left;
      int mode;
      int tick;
      seg_left = 0;
      mode = 0;
      tick = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(8, 64);
               mode = $urandom_range(0, 2);
            end
            seg_left--;
            tick++;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= (tick % 4 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         tracker.check_position({rsp_ch.shaft_pos, rsp_ch.electrical_pos,
                                 rsp_ch.commutation_index});
      end
   end

   initial begin
      int setting_cpr [FIXED_PHASES] = '{1, 16384, 32767, 0, 3, 12, 6000, 32767, 4000};
      int setting_cyc [FIXED_PHASES] = '{1, 1, 31, 4, 5, 0, 3, 1, 20};
      int setting_ofs [FIXED_PHASES] = '{-4096, 4095, -1, 100, 7, -5, 2047, -4096, 0};
      int cpr, cyc, ofs;
      int sent, burst, gap, step;
      int direction;
      logic [ecp_pkg::COUNTER_BITS-1:0] cv;

      reset <= 1'b1;
      hold_off_request = 1'b0;
      counter_now = '0;
      direction = 1;
      req_ch.valid         <= 1'b0;
      req_ch.counter_value <= '0;
      req_ch.drive_forward <= 1'b0;
      req_ch.phase_number  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= ecp_pkg::CSR_COUNTS_PER_REV;
      csr_ch.wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // counter extremes and half-range wraps at the reset setting
      send_sample(16'h0000, 1'b1, 2'd0);
      send_sample(16'h7FFF, 1'b0, 2'd1);
      send_sample(16'hFFFF, 1'b1, 2'd2);
      send_sample(16'h0000, 1'b0, 2'd3);
      send_sample(16'h8000, 1'b1, 2'd3);
      send_sample(16'h0001, 1'b0, 2'd2);

      for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
         if (p < FIXED_PHASES) begin
            cpr = setting_cpr[p];
            cyc = setting_cyc[p];
            ofs = setting_ofs[p];
         end else begin
            cpr = $urandom_range(1, 16384);
            cyc = $urandom_range(1, 20);
            ofs = $urandom_range(0, 8191) - 4096;
         end
         drain();
         apply_setting(cpr, cyc, ofs);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < ITEMS_PER_PHASE; b++) begin
               if ($urandom_range(0, 9) == 0) begin
                  direction = -direction;
               end
               if ($urandom_range(0, 99) < 75) begin
                  step = $urandom_range(0, 400);
                  cv = counter_now + ecp_pkg::COUNTER_BITS'(direction * step);
               end else begin
                  cv = ecp_pkg::COUNTER_BITS'($urandom);
               end
               send_sample(cv, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
               sent++;
               if (p == 2 && sent == 10) begin
                  hold_off_request = 1'b1;
               end
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
